// ----- rtl/olneu_pkg.sv -----
// shared widths, constants, sigmoid table and helper functions for the logistic neuron
`timescale 1ns / 1ps
package olneu_pkg;

	localparam int SIG_ENTRIES = 256;
	localparam int SIG_IDX_W   = $clog2(SIG_ENTRIES);

	localparam int FEAT_W = 16;
	localparam int Q_W    = 13;
	localparam int LR_W   = 16;
	localparam int W_W    = 24;
	localparam int ACC_W  = 42;
	localparam int MA_W   = 40;
	localparam int MB_W   = 17;
	localparam int PROD_W = MA_W + MB_W;
	localparam int STEP_W = 29;
	localparam int ERR_W  = 14;
	localparam int WD_W   = 19;
	localparam int BD_W   = 17;

	localparam logic [Q_W-1:0]  Q_ONE      = 13'd4096;
	localparam logic [LR_W-1:0] LR_DEFAULT = 16'd655;

	typedef logic [Q_W-1:0] sig_tab_t [SIG_ENTRIES];

	// quotient of two non-negative values, only used while the table is built
	function automatic longint quot_pos(input longint n, input longint d);
		longint q;
		longint r;
		q = 0;
		r = 0;
		for (int b = 62; b >= 0; b--) begin
			r = (r <<< 1) | ((n >>> b) & longint'(1));
			if (r >= d) begin
				r = r - d;
				q = q | (longint'(1) <<< b);
			end
		end
		return q;
	endfunction

	// e^-(t/2^28) in q.30, taylor series on t/16 then squared four times
	function automatic longint exp_neg(input longint t);
		longint y;
		longint sum;
		longint term;
		y    = t >>> 2;
		sum  = longint'(1) << 30;
		term = longint'(1) << 30;
		for (int i = 1; i <= 12; i++) begin
			term = quot_pos((term * y) >>> 30, longint'(i));
			if ((i & 1) != 0) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		for (int j = 0; j < 4; j++) begin
			sum = (sum * sum) >>> 30;
		end
		return sum;
	endfunction

	// sigmoid at each bin center over [-8,8), rounded to q0.12
	function automatic sig_tab_t build_sig_tab();
		sig_tab_t tab;
		longint   c;
		longint   t;
		longint   e;
		longint   den;
		longint   num;
		longint   one30;
		one30 = longint'(1) << 30;
		for (int k = 0; k < SIG_ENTRIES; k++) begin
			c = ((longint'(2 * k + 1) << 31) >> SIG_IDX_W) - (longint'(8) << 28);
			t = (c < 0) ? -c : c;
			e = exp_neg(t);
			den = one30 + e;
			num = (c >= 0) ? one30 : e;
			tab[k] = Q_W'(quot_pos(num * 4096 + (den >>> 1), den));
		end
		return tab;
	endfunction

	localparam sig_tab_t SIG_TAB = build_sig_tab();

	// clamp a weight sum back into the stored range
	function automatic logic signed [W_W-1:0] sat_w(input logic signed [W_W:0] v);
		if (v[W_W] != v[W_W-1]) begin
			return v[W_W] ? {1'b1, {(W_W-1){1'b0}}} : {1'b0, {(W_W-1){1'b1}}};
		end
		return v[W_W-1:0];
	endfunction

endpackage

// ----- rtl/olneu_in_if.sv -----
// sample channel: valid/ready plus mode, features and target
`timescale 1ns / 1ps
interface olneu_in_if;
	logic               valid;
	logic               ready;
	logic               mode;
	logic signed [15:0] feature_a;
	logic signed [15:0] feature_b;
	logic [12:0]        target;

	modport source (output valid, output mode, output feature_a, output feature_b,
		output target, input ready);
	modport sink (input valid, input mode, input feature_a, input feature_b,
		input target, output ready);
endinterface

// ----- rtl/olneu_out_if.sv -----
// result channel: valid/ready plus prediction and absolute error
`timescale 1ns / 1ps
interface olneu_out_if;
	logic        valid;
	logic        ready;
	logic [12:0] prediction;
	logic [12:0] abs_error;

	modport source (output valid, output prediction, output abs_error, input ready);
	modport sink (input valid, input prediction, input abs_error, output ready);
endinterface

// ----- rtl/olneu_mul.sv -----
// shared signed multiplier with registered product
`timescale 1ns / 1ps
module olneu_mul import olneu_pkg::*; (
	input  logic                     clk,
	input  logic signed [MA_W-1:0]   op_a,
	input  logic signed [MB_W-1:0]   op_b,
	output logic signed [PROD_W-1:0] prod
);

	logic signed [PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(op_a) * PROD_W'(op_b);
	end

	assign prod = prod_q;

endmodule

// ----- rtl/olneu_sig_lut.sv -----
// maps the q.28 weighted sum to a table index and reads the sigmoid value
`timescale 1ns / 1ps
module olneu_sig_lut import olneu_pkg::*; (
	input  logic signed [ACC_W-1:0] acc,
	output logic [Q_W-1:0]          p
);

	logic signed [ACC_W-1:0] v;
	logic [SIG_IDX_W-1:0]    idx;

	// shift so that -8.0 lands on zero; in range means 0 <= v < 2^32
	assign v = acc + (ACC_W'(1) <<< 31);

	always_comb begin
		if (v[ACC_W-1]) begin
			idx = '0;
		end else if (v[ACC_W-2:32] != '0) begin
			idx = SIG_IDX_W'(SIG_ENTRIES - 1);
		end else begin
			idx = v[31:32-SIG_IDX_W];
		end
	end

	assign p = SIG_TAB[idx];

endmodule

// ----- rtl/online_logistic_neuron.sv -----
// top level: sequencer and datapath of the online logistic neuron
//
//  channel   dir  handshake          payload
//  sample    in   valid/ready        mode, feature_a, feature_b, target
//  result    out  valid/ready        prediction, abs_error
//  cfg       in   cfg_we (no ready)  cfg_wdata = learn_rate
//
// predict and train requests all run on one shared 40x17 multiplier.
// sample.ready is high only while the sequencer is idle; one request is in flight.
// the result register lets the next request start while a result waits.
// arst_n clears weights and bias to zero and sets learn_rate to 655.
`timescale 1ns / 1ps
module online_logistic_neuron import olneu_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [LR_W-1:0]  cfg_wdata,
	olneu_in_if.sink         sample,
	olneu_out_if.source      result
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_MA    = 4'd1;
	localparam logic [3:0] S_MB    = 4'd2;
	localparam logic [3:0] S_SUM   = 4'd3;
	localparam logic [3:0] S_LOOK  = 4'd4;
	localparam logic [3:0] S_D     = 4'd5;
	localparam logic [3:0] S_DL    = 4'd6;
	localparam logic [3:0] S_STEP  = 4'd7;
	localparam logic [3:0] S_SHIFT = 4'd8;
	localparam logic [3:0] S_WA    = 4'd9;
	localparam logic [3:0] S_WB    = 4'd10;
	localparam logic [3:0] S_WBU   = 4'd11;
	localparam logic [3:0] S_OUT   = 4'd12;

	logic [3:0]               state_q;
	logic [LR_W-1:0]          learn_rate_q;
	logic signed [W_W-1:0]    wa_q;
	logic signed [W_W-1:0]    wb_q;
	logic signed [W_W-1:0]    bias_q;

	logic                     mode_q;
	logic signed [FEAT_W-1:0] xa_q;
	logic signed [FEAT_W-1:0] xb_q;
	logic [Q_W-1:0]           tgt_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic [Q_W-1:0]           p_q;
	logic signed [ERR_W-1:0]  err_q;
	logic signed [STEP_W-1:0] step_q;

	logic                     out_valid_q;
	logic [Q_W-1:0]           out_pred_q;
	logic [Q_W-1:0]           out_err_q;

	logic signed [MA_W-1:0]   mul_a;
	logic signed [MB_W-1:0]   mul_b;
	logic signed [PROD_W-1:0] prod;
	logic [Q_W-1:0]           lut_p;

	logic                     accept;
	logic                     out_load;
	logic signed [PROD_W-1:0] prod_rnd;
	logic signed [STEP_W-1:0] step_rnd;
	logic signed [WD_W-1:0]   w_dlt;
	logic signed [BD_W-1:0]   b_dlt;
	logic [Q_W-1:0]           err_mag;

	assign sample.ready = (state_q == S_IDLE);
	assign accept       = sample.valid && sample.ready;
	assign out_load     = (state_q == S_OUT) && (!out_valid_q || result.ready);

	// operand routing for the shared multiplier
	always_comb begin
		unique case (state_q)
			S_MA: begin
				mul_a = MA_W'(wa_q);
				mul_b = MB_W'(xa_q);
			end
			S_MB: begin
				mul_a = MA_W'(wb_q);
				mul_b = MB_W'(xb_q);
			end
			S_D: begin
				mul_a = MA_W'({1'b0, p_q});
				mul_b = MB_W'({1'b0, Q_ONE - p_q});
			end
			S_DL: begin
				mul_a = MA_W'({1'b0, prod[22:0]});
				mul_b = MB_W'({1'b0, learn_rate_q});
			end
			S_STEP: begin
				mul_a = MA_W'({1'b0, prod[38:0]});
				mul_b = MB_W'(err_q);
			end
			S_WA: begin
				mul_a = MA_W'(step_q);
				mul_b = MB_W'(xa_q);
			end
			S_WB: begin
				mul_a = MA_W'(step_q);
				mul_b = MB_W'(xb_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	olneu_mul u_mul (
		.clk  (clk),
		.op_a (mul_a),
		.op_b (mul_b),
		.prod (prod)
	);

	olneu_sig_lut u_sig_lut (
		.acc (acc_q),
		.p   (lut_p)
	);

	// round toward zero: bias negative values up before the arithmetic shift
	assign prod_rnd = prod + (prod[PROD_W-1] ? PROD_W'(24'hFF_FFFF) : '0);
	assign step_rnd = step_q + (step_q[STEP_W-1] ? STEP_W'(12'hFFF) : '0);
	assign w_dlt    = WD_W'(prod_rnd >>> 24);
	assign b_dlt    = BD_W'(step_rnd >>> 12);
	assign err_mag  = err_q[ERR_W-1] ? Q_W'(-err_q) : Q_W'(err_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			learn_rate_q <= LR_DEFAULT;
			wa_q         <= '0;
			wb_q         <= '0;
			bias_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				learn_rate_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_MA;
					end
				end
				S_MA:    state_q <= S_MB;
				S_MB:    state_q <= S_SUM;
				S_SUM:   state_q <= S_LOOK;
				S_LOOK:  state_q <= mode_q ? S_D : S_OUT;
				S_D:     state_q <= S_DL;
				S_DL:    state_q <= S_STEP;
				S_STEP:  state_q <= S_SHIFT;
				S_SHIFT: state_q <= S_WA;
				S_WA: begin
					bias_q  <= sat_w((W_W+1)'(bias_q) + (W_W+1)'(b_dlt));
					state_q <= S_WB;
				end
				S_WB: begin
					wa_q    <= sat_w((W_W+1)'(wa_q) + (W_W+1)'(w_dlt));
					state_q <= S_WBU;
				end
				S_WBU: begin
					wb_q    <= sat_w((W_W+1)'(wb_q) + (W_W+1)'(w_dlt));
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= sample.mode;
			xa_q   <= sample.feature_a;
			xb_q   <= sample.feature_b;
			tgt_q  <= (sample.target > Q_ONE) ? Q_ONE : sample.target;
		end
		if (state_q == S_MB) begin
			acc_q <= ACC_W'(prod) + {{(ACC_W-W_W-12){bias_q[W_W-1]}}, bias_q, 12'd0};
		end
		if (state_q == S_SUM) begin
			acc_q <= acc_q + ACC_W'(prod);
		end
		if (state_q == S_LOOK) begin
			p_q <= lut_p;
		end
		if (state_q == S_D) begin
			err_q <= $signed({1'b0, tgt_q}) - $signed({1'b0, p_q});
		end
		if (state_q == S_SHIFT) begin
			step_q <= STEP_W'(prod_rnd >>> 24);
		end
		if (out_load) begin
			out_pred_q <= p_q;
			out_err_q  <= mode_q ? err_mag : '0;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.prediction = out_pred_q;
	assign result.abs_error  = out_err_q;

`ifndef SYNTHESIS
	a_predict_no_error: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && !mode_q) |=> (result.abs_error == '0))
		else $error("abs_error not zero for a predict request");

	a_pred_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (result.prediction <= Q_ONE) && (result.abs_error <= Q_ONE))
		else $error("result outside q0.12 unit range");

	a_predict_keeps_weights: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE && !mode_q) |=> ($stable(wa_q) && $stable(wb_q) && $stable(bias_q)))
		else $error("weights changed during a predict request");

	a_no_load_over_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result.ready) |=> ($stable(result.prediction)
			&& $stable(result.abs_error)))
		else $error("pending result overwritten");
`endif

endmodule
